// ----- src/mmf_pkg.sv -----
// Shared types and constants for the moving median filter.
`default_nettype none
package mmf_pkg;

  localparam int unsigned WINDOW_DEPTH_DEFAULT = 16;
  localparam int unsigned TEMP_W = 15;
  localparam int unsigned HUM_W = 14;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temperature_sample;
    logic [HUM_W-1:0]         humidity_sample;
  } in_item_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temperature_median;
    logic [HUM_W-1:0]         humidity_median;
    logic                     window_full;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_MERGE,
    ST_MEDIAN,
    ST_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic capture;
    logic merge_init;
    logic merge_run;
    logic median_sel;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic merge_done;
    logic out_busy;
  } ctrl_status_t;

endpackage
`default_nettype wire

// ----- src/mmf_lane.sv -----
// One channel: ring window, ping-pong sorted copy and the merge sequencer.
`default_nettype none
module mmf_lane #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned W     = 14,
  parameter int unsigned IDX_W = 4,
  parameter int unsigned CNT_W = 5
) (
  input  wire                    clk,
  input  wire                    rst,
  input  mmf_pkg::ctrl_cmd_t     cmd,
  input  wire  [W-1:0]           sample,
  input  wire  [IDX_W-1:0]       write_slot,
  input  wire  [CNT_W-1:0]       n_old,
  input  wire  [IDX_W-1:0]       median_idx,
  input  wire                    rbank,
  output logic [W-1:0]           median,
  output logic                   done
);
  import mmf_pkg::*;

  localparam int unsigned SORT_DEPTH = 2 * (1 << IDX_W);

  logic [W-1:0] ring [DEPTH];
  logic [W-1:0] sorted [SORT_DEPTH];

  logic [W-1:0]     new_val;
  logic [W-1:0]     old_val;
  logic [W-1:0]     rd_q;
  logic [CNT_W-1:0] rd_ptr, rd_ptr_next, rd_ptr_inc;
  logic [CNT_W-1:0] wr_ptr, wr_ptr_next;
  logic             inserted, inserted_next;
  logic             deleted, deleted_next;
  logic             fetch, fetch_next;
  logic             done_next;
  logic             avail;
  logic [IDX_W:0]   rd_addr, wr_addr;
  logic             wr_en;
  logic [W-1:0]     wr_data;

  // read-first ring: old entry comes out as the new one goes in
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      old_val           <= ring[write_slot];
      ring[write_slot]  <= sample;
      new_val           <= sample;
    end
  end

  assign avail      = rd_ptr < n_old;
  assign rd_ptr_inc = rd_ptr + CNT_W'(1);
  assign rd_addr    = cmd.median_sel ? {~rbank, median_idx}
                                     : {rbank, (avail ? rd_ptr[IDX_W-1:0] : IDX_W'(0))};
  assign wr_addr    = {~rbank, wr_ptr[IDX_W-1:0]};

  always_comb begin
    rd_ptr_next   = rd_ptr;
    wr_ptr_next   = wr_ptr;
    inserted_next = inserted;
    deleted_next  = deleted;
    fetch_next    = fetch;
    done_next     = done;
    wr_en         = 1'b0;
    wr_data       = rd_q;
    if (cmd.merge_init) begin
      rd_ptr_next   = '0;
      wr_ptr_next   = '0;
      inserted_next = 1'b0;
      deleted_next  = (n_old != CNT_W'(DEPTH));
      fetch_next    = (n_old != '0);
      done_next     = 1'b0;
    end else if (cmd.merge_run && !done) begin
      if (fetch) begin
        fetch_next = 1'b0;
      end else if (avail && !deleted && rd_q == old_val) begin
        deleted_next = 1'b1;
        rd_ptr_next  = rd_ptr_inc;
        fetch_next   = rd_ptr_inc < n_old;
      end else if (!inserted && (!avail || new_val <= rd_q)) begin
        wr_en         = 1'b1;
        wr_data       = new_val;
        wr_ptr_next   = wr_ptr + CNT_W'(1);
        inserted_next = 1'b1;
      end else if (avail) begin
        wr_en       = 1'b1;
        wr_data     = rd_q;
        wr_ptr_next = wr_ptr + CNT_W'(1);
        rd_ptr_next = rd_ptr_inc;
        fetch_next  = rd_ptr_inc < n_old;
      end else begin
        done_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      sorted[wr_addr] <= wr_data;
    end
    rd_q <= sorted[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr   <= '0;
      wr_ptr   <= '0;
      inserted <= 1'b0;
      deleted  <= 1'b0;
      fetch    <= 1'b0;
      done     <= 1'b0;
    end else begin
      rd_ptr   <= rd_ptr_next;
      wr_ptr   <= wr_ptr_next;
      inserted <= inserted_next;
      deleted  <= deleted_next;
      fetch    <= fetch_next;
      done     <= done_next;
    end
  end

  assign median = rd_q;

endmodule
`default_nettype wire

// ----- src/mmf_datapath.sv -----
// Datapath: window counters, two channel lanes and the result register.
`default_nettype none
module mmf_datapath #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned IDX_W = 4,
  parameter int unsigned CNT_W = 5
) (
  input  wire                   clk,
  input  wire                   rst,
  input  mmf_pkg::ctrl_cmd_t    cmd,
  output mmf_pkg::ctrl_status_t status,
  input  mmf_pkg::in_item_t     sample,
  output mmf_pkg::out_item_t    median,
  output logic                  median_valid,
  input  wire                   median_stall
);
  import mmf_pkg::*;

  logic [IDX_W-1:0]  write_slot;
  logic [CNT_W-1:0]  fill_count;
  logic [CNT_W-1:0]  n_old;
  logic [CNT_W-1:0]  half_count;
  logic              rbank;
  logic [TEMP_W-1:0] temp_key;
  logic [TEMP_W-1:0] temp_med;
  logic [HUM_W-1:0]  hum_med;
  logic              temp_done;
  logic              hum_done;

  // offset binary so the lane compares unsigned
  assign temp_key   = {~sample.temperature_sample[TEMP_W-1],
                       sample.temperature_sample[TEMP_W-2:0]};
  assign half_count = fill_count >> 1;

  mmf_lane #(
    .DEPTH (DEPTH),
    .W     (TEMP_W),
    .IDX_W (IDX_W),
    .CNT_W (CNT_W)
  ) u_temp_lane (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sample     (temp_key),
    .write_slot (write_slot),
    .n_old      (n_old),
    .median_idx (half_count[IDX_W-1:0]),
    .rbank      (rbank),
    .median     (temp_med),
    .done       (temp_done)
  );

  mmf_lane #(
    .DEPTH (DEPTH),
    .W     (HUM_W),
    .IDX_W (IDX_W),
    .CNT_W (CNT_W)
  ) u_hum_lane (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sample     (sample.humidity_sample),
    .write_slot (write_slot),
    .n_old      (n_old),
    .median_idx (half_count[IDX_W-1:0]),
    .rbank      (rbank),
    .median     (hum_med),
    .done       (hum_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot   <= '0;
      fill_count   <= '0;
      n_old        <= '0;
      rbank        <= 1'b0;
      median_valid <= 1'b0;
    end else begin
      if (cmd.capture) begin
        write_slot <= (write_slot == IDX_W'(DEPTH - 1)) ? '0 : write_slot + IDX_W'(1);
        fill_count <= (fill_count == CNT_W'(DEPTH)) ? fill_count : fill_count + CNT_W'(1);
        n_old      <= fill_count;
      end
      if (cmd.finish) begin
        rbank        <= ~rbank;
        median_valid <= 1'b1;
      end else if (median_valid && !median_stall) begin
        median_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      median.temperature_median <= {~temp_med[TEMP_W-1], temp_med[TEMP_W-2:0]};
      median.humidity_median    <= hum_med;
      median.window_full        <= (fill_count == CNT_W'(DEPTH));
    end
  end

  assign status.merge_done = temp_done && hum_done;
  assign status.out_busy   = median_valid && median_stall;

endmodule
`default_nettype wire

// ----- src/mmf_ctrl.sv -----
// Controller state machine sequencing capture, merge, median read and result load.
`default_nettype none
module mmf_ctrl (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   sample_valid,
  output logic                  sample_stall,
  input  mmf_pkg::ctrl_status_t status,
  output mmf_pkg::ctrl_cmd_t    cmd
);
  import mmf_pkg::*;

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (sample_valid) state_next = ST_INIT;
      ST_INIT:   state_next = ST_MERGE;
      ST_MERGE:  if (status.merge_done) state_next = ST_MEDIAN;
      ST_MEDIAN: state_next = ST_DONE;
      ST_DONE:   if (!status.out_busy) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    sample_stall = 1'b1;
    case (state)
      ST_IDLE: begin
        sample_stall = 1'b0;
        cmd.capture  = sample_valid;
      end
      ST_INIT:   cmd.merge_init = 1'b1;
      ST_MERGE:  cmd.merge_run = 1'b1;
      ST_MEDIAN: cmd.median_sel = 1'b1;
      ST_DONE: begin
        cmd.median_sel = 1'b1;
        cmd.finish     = !status.out_busy;
      end
      default: cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

// ----- src/moving_median_filter.sv -----
// Top level of the two-channel running median filter.
// Each sample runs a merge pass over the N samples held before it, which reads the sorted
// copy one entry at a time; the median is then read from the merged copy. A new sample
// is taken only once the previous median has been loaded into the result register,
// later while a stalled median holds that register.
// Reset (rst, synchronous) empties the window and drops any pending result.
`default_nettype none
module moving_median_filter #(
  parameter int unsigned WINDOW_DEPTH = mmf_pkg::WINDOW_DEPTH_DEFAULT
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                sample_valid,
  output logic               sample_stall,
  input  mmf_pkg::in_item_t  sample,
  output logic               median_valid,
  input  wire                median_stall,
  output mmf_pkg::out_item_t median
);
  import mmf_pkg::*;

  localparam int unsigned IDX_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(WINDOW_DEPTH + 1);

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  mmf_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .status       (status),
    .cmd          (cmd)
  );

  mmf_datapath #(
    .DEPTH (WINDOW_DEPTH),
    .IDX_W (IDX_W),
    .CNT_W (CNT_W)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .sample       (sample),
    .median       (median),
    .median_valid (median_valid),
    .median_stall (median_stall)
  );

endmodule
`default_nettype wire

// ----- src/mmf_checker.sv -----
// Port-level checker for the moving median filter and its bind.
`default_nettype none
module mmf_checker (
  input wire                clk,
  input wire                rst,
  input wire                sample_valid,
  input wire                sample_stall,
  input mmf_pkg::in_item_t  sample,
  input wire                median_valid,
  input wire                median_stall,
  input mmf_pkg::out_item_t median
);
  import mmf_pkg::*;

  logic [1:0] pending;
  logic       full_seen;
  logic       in_xfer;
  logic       out_xfer;

  assign in_xfer  = sample_valid && !sample_stall;
  assign out_xfer = median_valid && !median_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending   <= '0;
      full_seen <= 1'b0;
    end else begin
      pending <= pending + {1'b0, in_xfer} - {1'b0, out_xfer};
      if (out_xfer && median.window_full) begin
        full_seen <= 1'b1;
      end
    end
  end

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> sample_stall)
    else $error("sample taken while previous one still in work");

  a_result_has_sample: assert property (@(posedge clk) disable iff (rst)
    out_xfer |-> (pending != 2'd0))
    else $error("median transfer without a pending sample");

  a_pending_bound: assert property (@(posedge clk) disable iff (rst)
    pending != 2'd3)
    else $error("more than two samples in flight");

  a_full_sticky: assert property (@(posedge clk) disable iff (rst)
    (median_valid && full_seen) |-> median.window_full)
    else $error("window_full dropped after being set");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (median_valid && median_stall) |=> (median_valid && $stable(median)))
    else $error("stalled median changed");

endmodule

bind moving_median_filter mmf_checker u_mmf_checker (.*);
`default_nettype wire

// ----- bench/median_checker.sv -----
// Checker for the moving median filter: predicts each window median and compares results.
`timescale 1ns / 1ps
module median_checker #(
  parameter int WIN = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               sample_valid,
  input  logic               sample_stall,
  input  mmf_pkg::in_item_t  sample,
  input  logic               median_valid,
  input  logic               median_stall,
  input  mmf_pkg::out_item_t median,
  output int                 errors,
  output int                 pending,
  output int                 checked,
  output int                 full_seen
);

  logic signed [14:0] temp_hist [WIN];
  logic [13:0]        hum_hist [WIN];
  int                 next_slot = 0;
  int                 held = 0;
  int                 mismatches = 0;
  mmf_pkg::out_item_t medians_due [$];
  mmf_pkg::out_item_t want;

  // Store the sample in the ring, then take the middle of a sorted copy per channel.
  function automatic mmf_pkg::out_item_t window_medians(mmf_pkg::in_item_t s);
    int srt [2][WIN];
    int v;
    int j;
    int n;
    mmf_pkg::out_item_t r;
    temp_hist[next_slot] = s.temperature_sample;
    hum_hist[next_slot] = s.humidity_sample;
    next_slot = (next_slot + 1) % WIN;
    if (held < WIN) held++;
    n = held;
    for (int ch = 0; ch < 2; ch++) begin
      for (int i = 0; i < n; i++) begin
        v = (ch == 0) ? int'($signed(temp_hist[i])) : int'(hum_hist[i]);
        j = i;
        while (j > 0 && srt[ch][j-1] > v) begin
          srt[ch][j] = srt[ch][j-1];
          j--;
        end
        srt[ch][j] = v;
      end
    end
    v = srt[0][n/2];
    r.temperature_median = v[14:0];
    v = srt[1][n/2];
    r.humidity_median = v[13:0];
    r.window_full = (held == WIN);
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      medians_due.delete();
      next_slot = 0;
      held = 0;
    end else begin
      if (median_valid && !median_stall) begin
        if (medians_due.size() == 0) begin
          errors++;
          mismatches++;
          if (mismatches <= 10)
            $display("%t: median transfer with nothing expected: T=%0d H=%0d F=%0d", $time,
                     $signed(median.temperature_median), median.humidity_median,
                     median.window_full);
        end else begin
          want = medians_due.pop_front();
          checked++;
          if (median.window_full) full_seen++;
          if (median.temperature_median !== want.temperature_median ||
              median.humidity_median !== want.humidity_median ||
              median.window_full !== want.window_full) begin
            errors++;
            mismatches++;
            if (mismatches <= 10)
              $display("%t: median #%0d expected T=%0d H=%0d F=%0d, got T=%0d H=%0d F=%0d",
                       $time, checked, $signed(want.temperature_median),
                       want.humidity_median, want.window_full,
                       $signed(median.temperature_median), median.humidity_median,
                       median.window_full);
          end
        end
      end
      if (sample_valid && !sample_stall)
        medians_due.push_back(window_medians(sample));
    end
    pending = medians_due.size();
  end

endmodule

// ----- bench/tb.sv -----
// Top of the moving median filter testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb;
  import mmf_pkg::*;

  localparam int WIN = WINDOW_DEPTH_DEFAULT;
  localparam int N_RANDOM = 625;
  localparam int LIMIT = 400000;
  localparam int DRAIN = 80;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      sample_valid = 1'b0;
  logic      sample_stall;
  in_item_t  sample = '0;
  logic      median_valid;
  logic      median_stall = 1'b0;
  out_item_t median;

  bit calm = 1'b0;
  int cycles = 0;
  int sent = 0;
  int directed = 0;
  int errors;
  int pending;
  int checked;
  int full_seen;

  moving_median_filter #(.WINDOW_DEPTH(WIN)) dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .median_valid (median_valid),
    .median_stall (median_stall),
    .median       (median)
  );

  median_checker #(.WIN(WIN)) u_median_checker (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .median_valid (median_valid),
    .median_stall (median_stall),
    .median       (median),
    .errors       (errors),
    .pending      (pending),
    .checked      (checked),
    .full_seen    (full_seen)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles, %0d medians outstanding", cycles, pending);
      $display("tb NOT OK");
      $finish;
    end
  end

  always @(negedge clk) begin
    median_stall <= !rst && !calm && ($urandom_range(0, 99) < 12);
  end

  function automatic in_item_t mk_item(int t, int h);
    in_item_t r;
    r.temperature_sample = t[14:0];
    r.humidity_sample = h[13:0];
    return r;
  endfunction

  // Mostly nominal readings; some raw full-width values, clustered ties and extremes.
  function automatic in_item_t rand_item();
    int pick;
    int t;
    int h;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      t = int'($urandom_range(0, 12500)) - 4000;
      h = $urandom_range(0, 10000);
    end else if (pick < 75) begin
      t = $urandom;
      h = $urandom;
    end else if (pick < 90) begin
      t = 2000 + 10 * $urandom_range(0, 3);
      h = 4000 + 5 * $urandom_range(0, 2);
    end else begin
      case ($urandom_range(0, 3))
        0: t = -4000;
        1: t = 8500;
        2: t = -16384;
        default: t = 16383;
      endcase
      case ($urandom_range(0, 2))
        0: h = 0;
        1: h = 10000;
        default: h = 16383;
      endcase
    end
    return mk_item(t, h);
  endfunction

  task automatic send(in_item_t it);
    calm = (sent >= 250 && sent < 400);
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < 12) begin
      sample_valid <= 1'b0;
      @(negedge clk);
    end
    sample_valid <= 1'b1;
    sample <= it;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
    sent++;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // extremes, out-of-range codes, ties, then a descending ramp that fills and wraps
    send(mk_item(0, 0));
    send(mk_item(8500, 10000));
    send(mk_item(-4000, 0));
    send(mk_item(16383, 16383));
    send(mk_item(-16384, 0));
    send(mk_item(-1, 1));
    send(mk_item(1, 16383));
    send(mk_item(2500, 5000));
    send(mk_item(2500, 5000));
    send(mk_item(2500, 4999));
    send(mk_item(-4000, 10000));
    send(mk_item(8500, 0));
    for (int i = 0; i < 12; i++)
      send(mk_item(8000 - 1000 * i, 10000 - 800 * i));
    directed = sent;

    for (int i = 0; i < N_RANDOM; i++)
      send(rand_item());

    @(negedge clk);
    sample_valid <= 1'b0;
    calm = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN) @(posedge clk);

    $display("%0d samples (%0d directed) through a %0d-deep window, %0d medians checked",
             sent, directed, WIN, checked);
    $display("%0d medians with a full window, %0d failures, %0d left over",
             full_seen, errors, pending);
    if (errors == 0 && pending == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
